FILE: design/lpmc_pkg.sv
// Shared constants, types and helper functions for the lidar motion compensation block.
`default_nettype none
package lpmc_pkg;

  // Q.30 fixed-point constants
  localparam logic [30:0]        Q30_ONE   = 31'd1073741824;
  localparam logic signed [31:0] Q30_ONE_S = 32'sd1073741824;
  localparam logic [31:0]        Q30_PI    = 32'd3373259426;
  localparam logic [31:0]        Q30_HALF_PI = 32'd1686629713;
  localparam logic signed [31:0] W_MAX     = 32'sd2147483647;

  // Sine series: Horner steps and pipeline depth of the sine unit
  localparam int SIN_STEPS = 5;
  localparam int SIN_LAT   = 2 + 3 * SIN_STEPS + 4;

  // Stages ahead of the sine units, and after them
  localparam int PRE_STAGES  = 5;
  localparam int POST_STAGES = 7;
  localparam int NUM_STAGES  = PRE_STAGES + SIN_LAT + POST_STAGES;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_END_TIME = 3'd0,
    REG_INV_SPAN       = 3'd1,
    REG_SHIFT_X        = 3'd2,
    REG_SHIFT_Y        = 3'd3,
    REG_SHIFT_Z        = 3'd4,
    REG_REL_ROTATION   = 3'd5,
    REG_ROT_ANGLE      = 3'd6,
    REG_INV_SIN_ANGLE  = 3'd7
  } lpmc_reg_t;

  // Reduced angle and square carried down the sine pipeline
  typedef struct packed {
    logic [30:0] r;
    logic        neg;
    logic [31:0] x2;
  } lpmc_sin_ctx_t;

  // Point payload that travels with every stage
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [7:0]         inten;
    logic               inv;
    logic signed [32:0] shx;
    logic signed [32:0] shy;
    logic signed [32:0] shz;
  } lpmc_pay_t;

  // Divisors of the sine series, innermost first
  function automatic logic [6:0] sin_div(input int k);
    logic [6:0] d;
    case (k)
      0: d = 7'd110;
      1: d = 7'd72;
      2: d = 7'd42;
      3: d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), for divide-by-constant through a multiply
  function automatic logic [29:0] sin_recip(input int k);
    logic [29:0] m;
    case (k)
      0: m = 30'd39045157;
      1: m = 30'd59652323;
      2: m = 30'd102261126;
      3: m = 30'd214748364;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

  // Clamp to +-(2^31 - 1)
  function automatic logic signed [31:0] clamp_w(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647)       r = W_MAX;
    else if (v < -48'sd2147483647) r = -W_MAX;
    else                           r = v[31:0];
    return r;
  endfunction

  // Rotation matrix entry from a quaternion product sum, clamped to [-1, 1]
  function automatic logic signed [31:0] mat_entry(input logic signed [64:0] v,
                                                   input logic diag);
    logic signed [64:0] sh;
    logic signed [64:0] e;
    logic signed [31:0] r;
    sh = v >>> 29;
    e  = diag ? (65'sd1073741824 - sh) : sh;
    if (e > 65'sd1073741824)       r = Q30_ONE_S;
    else if (e < -65'sd1073741824) r = -Q30_ONE_S;
    else                           r = e[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/lpmc_sin_weight.sv
// Pipelined slerp weight unit: sin(angle) * inv_sin, Q.30, clamped.
`default_nettype none
module lpmc_sin_weight (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [31:0]        angle_i,
  input  wire logic [31:0]        inv_sin_i,
  output logic signed [31:0]      c_o
);

  // Range reduction into [0, pi/2]
  logic [30:0] s0_r_r;
  logic        s0_neg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (angle_i >= lpmc_pkg::Q30_PI) begin
        s0_r_r   <= 31'(angle_i - lpmc_pkg::Q30_PI);
        s0_neg_r <= 1'b1;
      end else if (angle_i > lpmc_pkg::Q30_HALF_PI) begin
        s0_r_r   <= 31'(lpmc_pkg::Q30_PI - angle_i);
        s0_neg_r <= 1'b0;
      end else begin
        s0_r_r   <= angle_i[30:0];
        s0_neg_r <= 1'b0;
      end
    end
  end

  // Square of the reduced angle
  logic [61:0] s1_rr_r;
  logic [30:0] s1_r_r;
  logic        s1_neg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_rr_r  <= 62'(s0_r_r) * 62'(s0_r_r);
      s1_r_r   <= s0_r_r;
      s1_neg_r <= s0_neg_r;
    end
  end

  logic [30:0]              h_w   [0:lpmc_pkg::SIN_STEPS];
  lpmc_pkg::lpmc_sin_ctx_t  ctx_w [0:lpmc_pkg::SIN_STEPS];

  assign h_w[0]   = lpmc_pkg::Q30_ONE;
  assign ctx_w[0] = '{r: s1_r_r, neg: s1_neg_r, x2: s1_rr_r[61:30]};

  // Horner steps: h = 1 - ((x2 * h) >> 30) / d, three stages each
  for (genvar k = 0; k < lpmc_pkg::SIN_STEPS; k++) begin : g_step
    localparam logic [6:0]  DIV = lpmc_pkg::sin_div(k);
    localparam logic [29:0] RCP = lpmc_pkg::sin_recip(k);

    logic [62:0]             a_prod_r;
    lpmc_pkg::lpmc_sin_ctx_t a_ctx_r;
    logic [31:0]             b_v_r;
    logic [61:0]             b_mq_r;
    lpmc_pkg::lpmc_sin_ctx_t b_ctx_r;
    logic [30:0]             c_h_r;
    lpmc_pkg::lpmc_sin_ctx_t c_ctx_r;
    logic [29:0]             q0;
    logic [31:0]             qd;
    logic [31:0]             rem;
    logic [29:0]             q;

    // quotient estimate is exact or one low; one compare fixes it
    always_comb begin
      q0  = b_mq_r[61:32];
      qd  = 32'({2'b0, q0} * {25'b0, DIV});
      rem = b_v_r - qd;
      q   = q0 + 30'(rem >= {25'b0, DIV});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod_r <= 63'(ctx_w[k].x2) * 63'(h_w[k]);
        a_ctx_r  <= ctx_w[k];
        b_v_r    <= a_prod_r[61:30];
        b_mq_r   <= 62'(a_prod_r[61:30]) * 62'(RCP);
        b_ctx_r  <= a_ctx_r;
        c_h_r    <= lpmc_pkg::Q30_ONE - {1'b0, q};
        c_ctx_r  <= b_ctx_r;
      end
    end

    assign h_w[k+1]   = c_h_r;
    assign ctx_w[k+1] = c_ctx_r;
  end

  // Final sine product, clamp, sign, scale and clamp
  logic [61:0]        f1_prod_r;
  logic               f1_neg_r;
  logic signed [31:0] f2_s_r;
  logic signed [63:0] f3_m_r;
  logic [31:0]        hs;
  logic [31:0]        hc;
  logic signed [63:0] f4_v;

  always_comb begin
    hs   = f1_prod_r[61:30];
    hc   = (hs > 32'(lpmc_pkg::Q30_ONE)) ? 32'(lpmc_pkg::Q30_ONE) : hs;
    f4_v = f3_m_r >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod_r <= 62'(ctx_w[lpmc_pkg::SIN_STEPS].r) * 62'(h_w[lpmc_pkg::SIN_STEPS]);
      f1_neg_r  <= ctx_w[lpmc_pkg::SIN_STEPS].neg;
      f2_s_r    <= f1_neg_r ? -$signed(hc) : $signed(hc);
      f3_m_r    <= f2_s_r * $signed({1'b0, inv_sin_i});
      c_o       <= lpmc_pkg::clamp_w(f4_v[47:0]);
    end
  end

endmodule
`default_nettype wire

FILE: design/lidar_point_motion_compensation.sv
// Top level: lidar point motion compensation pipeline with configuration registers.
//
// Moves each lidar point to the frame-end pose: weight t from the timestamp, slerp of the
// relative rotation, rotation of the point and t times the frame translation, saturated.
// One point is accepted every clock cycle while the pipeline is not held. A point passes
// through 5 stages for weight and angles, 21 in the sine units and 7 for quaternion,
// matrix and rotation. Each register stage holds one multiplier level. When the output
// register is full and out_tready is low, the whole pipeline holds and in_tready drops.
// Invalid points pass through with coordinates unchanged. Configuration is to be written
// by the user only while the pipeline is empty; the block itself does not enforce this.
`default_nettype none
module lidar_point_motion_compensation (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [63:0]  cfg_wdata,
  // input points
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [167:0] in_tdata,  // point_x, point_y, point_z, point_intensity, point_time
  input  wire logic         in_tuser,  // point_invalid
  // compensated points
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata, // out_x, out_y, out_z, out_intensity
  output logic              out_tuser  // out_invalid
);

  localparam int NST  = lpmc_pkg::NUM_STAGES;
  localparam int SIN0 = lpmc_pkg::PRE_STAGES;
  localparam int U1   = lpmc_pkg::PRE_STAGES + lpmc_pkg::SIN_LAT;

  // Configuration registers
  logic [63:0]        cfg_fet_r;
  logic [47:0]        cfg_inv_span_r;
  logic signed [31:0] cfg_shx_r;
  logic signed [31:0] cfg_shy_r;
  logic signed [31:0] cfg_shz_r;
  logic [63:0]        cfg_rot_r;
  logic [31:0]        cfg_angle_r;
  logic [31:0]        cfg_inv_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fet_r      <= '0;
      cfg_inv_span_r <= '0;
      cfg_shx_r      <= '0;
      cfg_shy_r      <= '0;
      cfg_shz_r      <= '0;
      cfg_rot_r      <= 64'h8000_0000_0000_0000;
      cfg_angle_r    <= '0;
      cfg_inv_sin_r  <= '0;
    end else if (cfg_we) begin
      case (lpmc_pkg::lpmc_reg_t'(cfg_addr))
        lpmc_pkg::REG_FRAME_END_TIME: cfg_fet_r      <= cfg_wdata;
        lpmc_pkg::REG_INV_SPAN:       cfg_inv_span_r <= cfg_wdata[47:0];
        lpmc_pkg::REG_SHIFT_X:        cfg_shx_r      <= cfg_wdata[31:0];
        lpmc_pkg::REG_SHIFT_Y:        cfg_shy_r      <= cfg_wdata[31:0];
        lpmc_pkg::REG_SHIFT_Z:        cfg_shz_r      <= cfg_wdata[31:0];
        lpmc_pkg::REG_REL_ROTATION:   cfg_rot_r      <= cfg_wdata;
        lpmc_pkg::REG_ROT_ANGLE:      cfg_angle_r    <= cfg_wdata[31:0];
        lpmc_pkg::REG_INV_SIN_ANGLE:  cfg_inv_sin_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the whole pipe moves unless the output is held
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Valid bits and payload
  logic [NST-1:0]      vld_r;
  lpmc_pkg::lpmc_pay_t pay_r [0:NST-1];
  lpmc_pkg::lpmc_pay_t in_pay;

  assign in_pay = '{px: in_tdata[31:0], py: in_tdata[63:32], pz: in_tdata[95:64],
                    inten: in_tdata[103:96], inv: in_tuser,
                    shx: '0, shy: '0, shz: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Stage registers
  logic [63:0]        s1_diff_r;
  logic               s1_zero_r;
  logic [63:0]        s2_p00_r;
  logic [47:0]        s2_p01_r;
  logic [63:0]        s2_p10_r;
  logic [47:0]        s2_p11_r;
  logic               s2_zero_r;
  logic [30:0]        s3_t_r;
  logic [62:0]        s4_pa0_r;
  logic [62:0]        s4_pa1_r;
  logic signed [63:0] s4_shp_r [0:2];
  logic [31:0]        s5_a0_r;
  logic [31:0]        s5_a1_r;
  logic signed [31:0] c0;
  logic signed [31:0] c1;
  logic signed [31:0] u1_c0_r;
  logic signed [47:0] u1_pw_r;
  logic signed [47:0] u1_px_r;
  logic signed [47:0] u1_py_r;
  logic signed [47:0] u1_pz_r;
  logic signed [31:0] u2_qw_r;
  logic signed [31:0] u2_qx_r;
  logic signed [31:0] u2_qy_r;
  logic signed [31:0] u2_qz_r;
  logic signed [63:0] u3_xx_r, u3_yy_r, u3_zz_r, u3_xy_r, u3_xz_r;
  logic signed [63:0] u3_yz_r, u3_wx_r, u3_wy_r, u3_wz_r;
  logic signed [31:0] u4_m_r  [0:8];
  logic signed [63:0] u5_mp_r [0:8];
  logic signed [35:0] u6_o_r  [0:2];
  logic signed [31:0] u7_o_r  [0:2];

  // Payload entering stage 5 picks up the scaled translation
  lpmc_pkg::lpmc_pay_t pay_s5;
  always_comb begin
    pay_s5     = pay_r[SIN0-2];
    pay_s5.shx = s4_shp_r[0][62:30];
    pay_s5.shy = s4_shp_r[1][62:30];
    pay_s5.shz = s4_shp_r[2][62:30];
  end

  // Stage 1: time difference
  logic [63:0] in_time;
  assign in_time = in_tdata[167:104];

  // Stage 3: weight t from partial products, saturated to one
  logic [16:0] mid;
  logic [46:0] t_raw;
  logic [30:0] t_nxt;
  always_comb begin
    mid   = {1'b0, s2_p01_r[15:0]} + {1'b0, s2_p10_r[15:0]};
    t_raw = 47'(s2_p00_r[63:18]) + 47'({mid, 14'b0});
    if (s2_zero_r) begin
      t_nxt = '0;
    end else if (s2_p11_r != '0 || s2_p01_r >= 48'd65536 || s2_p10_r >= 64'd65536
                 || mid >= 17'd65536 || t_raw > 47'(lpmc_pkg::Q30_ONE)) begin
      t_nxt = lpmc_pkg::Q30_ONE;
    end else begin
      t_nxt = t_raw[30:0];
    end
  end

  // Quaternion components
  logic signed [15:0] rq_w, rq_x, rq_y, rq_z;
  logic signed [31:0] c1_adj;
  assign rq_w   = cfg_rot_r[63:48];
  assign rq_x   = cfg_rot_r[47:32];
  assign rq_y   = cfg_rot_r[31:16];
  assign rq_z   = cfg_rot_r[15:0];
  assign c1_adj = (rq_w <= 16'sd0) ? -c1 : c1;

  // Matrix sums
  logic signed [64:0] sm [0:8];
  always_comb begin
    sm[0] = 65'(u3_yy_r) + 65'(u3_zz_r);
    sm[1] = 65'(u3_xy_r) - 65'(u3_wz_r);
    sm[2] = 65'(u3_xz_r) + 65'(u3_wy_r);
    sm[3] = 65'(u3_xy_r) + 65'(u3_wz_r);
    sm[4] = 65'(u3_xx_r) + 65'(u3_zz_r);
    sm[5] = 65'(u3_yz_r) - 65'(u3_wx_r);
    sm[6] = 65'(u3_xz_r) - 65'(u3_wy_r);
    sm[7] = 65'(u3_yz_r) + 65'(u3_wx_r);
    sm[8] = 65'(u3_xx_r) + 65'(u3_yy_r);
  end

  // Rotated rows
  logic signed [65:0] row [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row[i] = 66'(u5_mp_r[3*i]) + 66'(u5_mp_r[3*i+1]) + 66'(u5_mp_r[3*i+2]);
    end
  end

  // Final add of translation and saturation
  logic signed [36:0] fin [0:2];
  logic signed [32:0] pay_sh [0:2];
  logic signed [31:0] pay_p  [0:2];
  assign pay_sh[0] = pay_r[NST-2].shx;
  assign pay_sh[1] = pay_r[NST-2].shy;
  assign pay_sh[2] = pay_r[NST-2].shz;
  assign pay_p[0]  = pay_r[NST-2].px;
  assign pay_p[1]  = pay_r[NST-2].py;
  assign pay_p[2]  = pay_r[NST-2].pz;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = 37'(u6_o_r[i]) + 37'(pay_sh[i]);
    end
  end

  // Pipeline data path
  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r[0] <= in_pay;
      for (int i = 1; i < NST; i++) begin
        if (i == SIN0 - 1) begin
          pay_r[i] <= pay_s5;
        end else begin
          pay_r[i] <= pay_r[i-1];
        end
      end
      // stage 1
      s1_diff_r <= cfg_fet_r - in_time;
      s1_zero_r <= (in_time >= cfg_fet_r) || (cfg_inv_span_r == '0);
      // stage 2
      s2_p00_r  <= 64'(s1_diff_r[31:0])  * 64'(cfg_inv_span_r[31:0]);
      s2_p01_r  <= 48'(s1_diff_r[31:0])  * 48'(cfg_inv_span_r[47:32]);
      s2_p10_r  <= 64'(s1_diff_r[63:32]) * 64'(cfg_inv_span_r[31:0]);
      s2_p11_r  <= 48'(s1_diff_r[63:32]) * 48'(cfg_inv_span_r[47:32]);
      s2_zero_r <= s1_zero_r;
      // stage 3
      s3_t_r    <= t_nxt;
      // stage 4: interpolated angles and translation products
      s4_pa0_r    <= 63'(lpmc_pkg::Q30_ONE - s3_t_r) * 63'(cfg_angle_r);
      s4_pa1_r    <= 63'(s3_t_r) * 63'(cfg_angle_r);
      s4_shp_r[0] <= cfg_shx_r * $signed({1'b0, s3_t_r});
      s4_shp_r[1] <= cfg_shy_r * $signed({1'b0, s3_t_r});
      s4_shp_r[2] <= cfg_shz_r * $signed({1'b0, s3_t_r});
      // stage 5
      s5_a0_r        <= s4_pa0_r[61:30];
      s5_a1_r        <= s4_pa1_r[61:30];
      // quaternion scaling
      u1_c0_r <= c0;
      u1_pw_r <= c1_adj * rq_w;
      u1_px_r <= c1_adj * rq_x;
      u1_py_r <= c1_adj * rq_y;
      u1_pz_r <= c1_adj * rq_z;
      // interpolated quaternion
      u2_qw_r <= lpmc_pkg::clamp_w(48'(u1_c0_r) + (u1_pw_r >>> 15));
      u2_qx_r <= lpmc_pkg::clamp_w(u1_px_r >>> 15);
      u2_qy_r <= lpmc_pkg::clamp_w(u1_py_r >>> 15);
      u2_qz_r <= lpmc_pkg::clamp_w(u1_pz_r >>> 15);
      // quaternion products
      u3_xx_r <= u2_qx_r * u2_qx_r;
      u3_yy_r <= u2_qy_r * u2_qy_r;
      u3_zz_r <= u2_qz_r * u2_qz_r;
      u3_xy_r <= u2_qx_r * u2_qy_r;
      u3_xz_r <= u2_qx_r * u2_qz_r;
      u3_yz_r <= u2_qy_r * u2_qz_r;
      u3_wx_r <= u2_qw_r * u2_qx_r;
      u3_wy_r <= u2_qw_r * u2_qy_r;
      u3_wz_r <= u2_qw_r * u2_qz_r;
      // rotation matrix
      for (int i = 0; i < 9; i++) begin
        u4_m_r[i] <= lpmc_pkg::mat_entry(sm[i], (i == 0) || (i == 4) || (i == 8));
      end
      // matrix times point
      for (int i = 0; i < 3; i++) begin
        u5_mp_r[3*i]   <= u4_m_r[3*i]   * pay_r[U1+3].px;
        u5_mp_r[3*i+1] <= u4_m_r[3*i+1] * pay_r[U1+3].py;
        u5_mp_r[3*i+2] <= u4_m_r[3*i+2] * pay_r[U1+3].pz;
      end
      // row sums; a zero angle keeps the point unrotated
      if (cfg_angle_r == '0) begin
        u6_o_r[0] <= 36'(pay_r[U1+4].px);
        u6_o_r[1] <= 36'(pay_r[U1+4].py);
        u6_o_r[2] <= 36'(pay_r[U1+4].pz);
      end else begin
        for (int i = 0; i < 3; i++) begin
          u6_o_r[i] <= row[i][65:30];
        end
      end
      // output register
      for (int i = 0; i < 3; i++) begin
        if (pay_r[NST-2].inv) begin
          u7_o_r[i] <= pay_p[i];
        end else if (fin[i] > 37'sd2147483647) begin
          u7_o_r[i] <= 32'sh7fffffff;
        end else if (fin[i] < -37'sd2147483648) begin
          u7_o_r[i] <= 32'sh80000000;
        end else begin
          u7_o_r[i] <= fin[i][31:0];
        end
      end
    end
  end

  // Slerp weights for identity and relative rotation
  lpmc_sin_weight u_sin0 (
    .clk       (clk),
    .en        (adv),
    .angle_i   (s5_a0_r),
    .inv_sin_i (cfg_inv_sin_r),
    .c_o       (c0)
  );

  lpmc_sin_weight u_sin1 (
    .clk       (clk),
    .en        (adv),
    .angle_i   (s5_a1_r),
    .inv_sin_i (cfg_inv_sin_r),
    .c_o       (c1)
  );

  // Outputs
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {pay_r[NST-1].inten, u7_o_r[2], u7_o_r[1], u7_o_r[0]};
  assign out_tuser  = pay_r[NST-1].inv;

  // Checks
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (s3_t_r <= lpmc_pkg::Q30_ONE))
    else $error("weight t above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && rst_n) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[U1] |-> (u1_c0_r <= lpmc_pkg::W_MAX && u1_c0_r >= -lpmc_pkg::W_MAX))
    else $error("slerp weight out of range");

  a_mat_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[U1+3] |-> (u4_m_r[0] <= lpmc_pkg::Q30_ONE_S && u4_m_r[0] >= -lpmc_pkg::Q30_ONE_S))
    else $error("matrix entry out of range");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the lidar point motion compensation pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  // Point in and compensated point out
  typedef struct {
    logic signed [31:0] x, y, z;
    logic [7:0]         inten;
    logic [63:0]        stamp;
    logic               inv;
  } point_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [7:0]         inten;
    logic               inv;
  } comp_t;

  // Directed row: expected coordinates typed in, valid under reset settings only
  typedef struct {
    logic signed [31:0] x, y, z;
    logic [7:0]         inten;
    logic [63:0]        stamp;
    logic               inv;
    logic signed [31:0] ex, ey, ez;
  } dir_row_t;

  localparam int NUM_ROWS = 14;
  localparam int WD_LIMIT = 4000;
  localparam int TAIL     = lpmc_pkg::NUM_STAGES + 8;
  localparam longint ONE  = 64'sd1073741824;
  localparam longint WLIM = 64'sd2147483647;

  // Under reset settings t = 0 and no rotation, so coordinates come back as they went in
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{32'sh0, 32'sh0, 32'sh0, 8'h00, 64'h0, 1'b0, 32'sh0, 32'sh0, 32'sh0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 8'hff, 64'hffffffffffffffff, 1'b0,
      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
    '{-32'sh80000000, -32'sh80000000, -32'sh80000000, 8'h00, 64'h0, 1'b0,
      -32'sh80000000, -32'sh80000000, -32'sh80000000},
    '{32'sh7fffffff, -32'sh80000000, 32'sh0, 8'h5a, 64'h1, 1'b0,
      32'sh7fffffff, -32'sh80000000, 32'sh0},
    '{-32'sh80000000, 32'sh7fffffff, -32'sh1, 8'ha5, 64'h8000000000000000, 1'b0,
      -32'sh80000000, 32'sh7fffffff, -32'sh1},
    '{32'sh00010000, 32'sh00020000, 32'sh00030000, 8'h7f, 64'h00000000ffffffff, 1'b0,
      32'sh00010000, 32'sh00020000, 32'sh00030000},
    '{32'sh12345678, -32'sh12345678, 32'sh55555555, 8'h80, 64'hfffffffffffffffe, 1'b0,
      32'sh12345678, -32'sh12345678, 32'sh55555555},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 8'hff, 64'h0, 1'b1,
      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
    '{-32'sh80000000, -32'sh80000000, -32'sh80000000, 8'h00, 64'hffffffffffffffff, 1'b1,
      -32'sh80000000, -32'sh80000000, -32'sh80000000},
    '{-32'sh1, -32'sh1, -32'sh1, 8'h01, 64'haaaaaaaaaaaaaaaa, 1'b1,
      -32'sh1, -32'sh1, -32'sh1},
    '{32'sh2aaaaaaa, 32'sh55555555, -32'sh2aaaaaab, 8'haa, 64'h5555555555555555, 1'b0,
      32'sh2aaaaaaa, 32'sh55555555, -32'sh2aaaaaab},
    '{32'sh0, -32'sh1, 32'sh1, 8'h55, 64'h00000001_00000000, 1'b0,
      32'sh0, -32'sh1, 32'sh1},
    '{32'sh00000001, 32'sh0, 32'sh7ffffffe, 8'hfe, 64'h7fffffffffffffff, 1'b1,
      32'sh00000001, 32'sh0, 32'sh7ffffffe},
    '{-32'sh7fffffff, 32'sh40000000, 32'sh0, 8'h10, 64'h0000000000000400, 1'b0,
      -32'sh7fffffff, 32'sh40000000, 32'sh0}
  };

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tuser;

  // Shadow copy of the register file
  logic [63:0] frame_end;
  logic [47:0] span_recip;
  logic [31:0] shift_v [3];
  logic [63:0] rel_quat;
  logic [31:0] angle;
  logic [31:0] sin_recip_v;
  longint      span_ns;

  comp_t  pending_q [$];
  int     errors;
  bit     idle_on;
  int     quiet_cycles;
  int     stall_left;

  lidar_point_motion_compensation u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Truncated sine series in Q.30 with quadrant folding
  function automatic longint sine_q30(logic [63:0] a);
    logic [63:0] r, x2, h;
    logic [63:0] divs [5];
    bit neg;
    divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    neg = 1'b0;
    if (a >= 64'(lpmc_pkg::Q30_PI)) begin
      r = a - 64'(lpmc_pkg::Q30_PI);
      neg = 1'b1;
    end else if (a > 64'(lpmc_pkg::Q30_HALF_PI)) begin
      r = 64'(lpmc_pkg::Q30_PI) - a;
    end else begin
      r = a;
    end
    x2 = (r * r) >> 30;
    h = 64'(ONE);
    for (int i = 0; i < 5; i++)
      h = 64'(ONE) - (((x2 * h) >> 30) / divs[i]);
    h = (r * h) >> 30;
    if (h > 64'(ONE)) h = 64'(ONE);
    return neg ? -longint'(h) : longint'(h);
  endfunction

  // Interpolation weight t in Q0.30 from the point timestamp
  function automatic longint frame_weight(logic [63:0] stamp);
    logic [63:0] diff, d0, d1, i0, i1, p00, p01, p10, p11, mid, t;
    if (stamp >= frame_end || span_recip == 0) return 0;
    diff = frame_end - stamp;
    d0 = {32'h0, diff[31:0]};
    d1 = {32'h0, diff[63:32]};
    i0 = {32'h0, span_recip[31:0]};
    i1 = {48'h0, span_recip[47:32]};
    p00 = d0 * i0;
    p01 = d0 * i1;
    p10 = d1 * i0;
    p11 = d1 * i1;
    if (p11 != 0 || p01 >= 65536 || p10 >= 65536) return ONE;
    mid = p01 + p10;
    if (mid >= 65536) return ONE;
    t = (p00 >> 18) + (mid << 14);
    return t > 64'(ONE) ? ONE : longint'(t);
  endfunction

  function automatic longint slerp_coef(logic [63:0] a);
    longint v;
    v = (sine_q30(a) * longint'({32'h0, sin_recip_v})) >>> 16;
    return lim(v, -WLIM, WLIM);
  endfunction

  function automatic longint rot_entry(longint v, bit diag);
    longint e;
    e = diag ? ONE - (v >>> 29) : (v >>> 29);
    return lim(e, -ONE, ONE);
  endfunction

  // Expected compensated point under the current register settings
  function automatic comp_t compensate(point_t p);
    comp_t  r;
    longint pv [3], ov [3], mm [3][3];
    longint t, c0, c1, qw, qx, qy, qz, w, x, y, z, v;
    logic [63:0] a0, a1;
    r.inten = p.inten;
    r.inv   = p.inv;
    if (p.inv) begin
      r.x = p.x; r.y = p.y; r.z = p.z;
      return r;
    end
    pv[0] = longint'(p.x);
    pv[1] = longint'(p.y);
    pv[2] = longint'(p.z);
    t = frame_weight(p.stamp);
    if (angle == 0) begin
      ov = pv;
    end else begin
      w = longint'($signed(rel_quat[63:48]));
      x = longint'($signed(rel_quat[47:32]));
      y = longint'($signed(rel_quat[31:16]));
      z = longint'($signed(rel_quat[15:0]));
      a0 = (64'(ONE - t) * {32'h0, angle}) >> 30;
      a1 = (64'(t) * {32'h0, angle}) >> 30;
      c0 = slerp_coef(a0);
      c1 = slerp_coef(a1);
      // zero w counts as negative
      if (w <= 0) c1 = -c1;
      qw = lim(c0 + ((c1 * w) >>> 15), -WLIM, WLIM);
      qx = lim((c1 * x) >>> 15, -WLIM, WLIM);
      qy = lim((c1 * y) >>> 15, -WLIM, WLIM);
      qz = lim((c1 * z) >>> 15, -WLIM, WLIM);
      mm[0][0] = rot_entry(qy * qy + qz * qz, 1'b1);
      mm[0][1] = rot_entry(qx * qy - qw * qz, 1'b0);
      mm[0][2] = rot_entry(qx * qz + qw * qy, 1'b0);
      mm[1][0] = rot_entry(qx * qy + qw * qz, 1'b0);
      mm[1][1] = rot_entry(qx * qx + qz * qz, 1'b1);
      mm[1][2] = rot_entry(qy * qz - qw * qx, 1'b0);
      mm[2][0] = rot_entry(qx * qz - qw * qy, 1'b0);
      mm[2][1] = rot_entry(qy * qz + qw * qx, 1'b0);
      mm[2][2] = rot_entry(qx * qx + qy * qy, 1'b1);
      for (int i = 0; i < 3; i++)
        ov[i] = (mm[i][0] * pv[0] + mm[i][1] * pv[1] + mm[i][2] * pv[2]) >>> 30;
    end
    for (int i = 0; i < 3; i++) begin
      v = ov[i] + ((t * longint'($signed(shift_v[i]))) >>> 30);
      pv[i] = lim(v, -64'sd2147483648, 64'sd2147483647);
    end
    r.x = pv[0][31:0];
    r.y = pv[1][31:0];
    r.z = pv[2][31:0];
    return r;
  endfunction

  // Register writes, one per cycle, mirrored into the shadow copy
  task automatic write_regs(logic [63:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (lpmc_pkg::lpmc_reg_t'(i))
        lpmc_pkg::REG_FRAME_END_TIME: frame_end   = vals[i];
        lpmc_pkg::REG_INV_SPAN:       span_recip  = vals[i][47:0];
        lpmc_pkg::REG_SHIFT_X:        shift_v[0]  = vals[i][31:0];
        lpmc_pkg::REG_SHIFT_Y:        shift_v[1]  = vals[i][31:0];
        lpmc_pkg::REG_SHIFT_Z:        shift_v[2]  = vals[i][31:0];
        lpmc_pkg::REG_REL_ROTATION:   rel_quat    = vals[i];
        lpmc_pkg::REG_ROT_ANGLE:      angle       = vals[i][31:0];
        lpmc_pkg::REG_INV_SIN_ANGLE:  sin_recip_v = vals[i][31:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One point transaction, with an optional idle burst ahead of it
  task automatic send_point(point_t p, bit typed, comp_t typed_exp);
    comp_t e;
    int gap;
    e = typed ? typed_exp : compensate(p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.stamp, p.inten, p.z, p.y, p.x};
    in_tuser  <= p.inv;
    do @(posedge clk); while (!in_tready);
    pending_q.insert(pending_q.size(), e);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Settings: 0 reset, 1 upper extremes, 2 lower extremes with zero w, else realistic frame
  task automatic pick_settings(int kind);
    logic [63:0] v [8];
    case (kind)
      0: begin
        v = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h8000000000000000, 64'h0, 64'h0};
        span_ns = 1000;
      end
      1: begin
        v = '{64'hffffffffffffffff, 64'hffffffffffff, 64'h7fffffff, 64'h7fffffff,
              64'h7fffffff, 64'hffffffffffffffff, 64'hffffffff, 64'hffffffff};
        span_ns = 1000;
      end
      2: begin
        v = '{64'h0000000100000000, 64'h0000000001, 64'h80000000, 64'h80000000,
              64'h80000000, {16'h0000, 16'h7fff, 16'h8000, 16'h4000},
              64'(lpmc_pkg::Q30_PI) + 64'h1000, 64'h00010000};
        span_ns = 64'h0000000100000000;
      end
      default: begin
        span_ns = $urandom_range(1000, 100000000);
        v[0] = {$urandom, $urandom};
        v[1] = (64'h1 << 48) / span_ns;
        for (int i = 2; i < 5; i++)
          v[i] = ($urandom_range(0, 3) == 0) ? 64'($urandom)
                 : 64'(32'($urandom_range(0, 2 ** 24) - 2 ** 23));
        v[5] = {$urandom, $urandom};
        v[6] = ($urandom_range(0, 3) == 0) ? 64'($urandom)
               : 64'($urandom_range(1, lpmc_pkg::Q30_HALF_PI));
        v[7] = ($urandom_range(0, 3) == 0) ? 64'($urandom)
               : 64'($urandom_range(32'h10000, 32'h400000));
      end
    endcase
    write_regs(v);
  endtask

  function automatic point_t random_point();
    point_t p;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      p.x = $urandom_range(0, 2 ** 24) - 2 ** 23;
      p.y = $urandom_range(0, 2 ** 24) - 2 ** 23;
      p.z = $urandom_range(0, 2 ** 22) - 2 ** 21;
      p.stamp = frame_end - 64'($urandom_range(0, 32'(span_ns + span_ns / 4)));
    end else begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
      p.stamp = (sel == 7) ? frame_end + 64'($urandom) : {$urandom, $urandom};
    end
    p.inten = 8'($urandom);
    p.inv   = ($urandom_range(0, 9) == 0);
    return p;
  endfunction

  // Receiver readiness with stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    comp_t e;
    comp_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.x = out_tdata[31:0];
      g.y = out_tdata[63:32];
      g.z = out_tdata[95:64];
      g.inten = out_tdata[103:96];
      g.inv = out_tuser;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%h y=%h z=%h", $time, g.x, g.y, g.z);
      end else begin
        e = pending_q.pop_front();
        if (g.x !== e.x) begin
          errors++;
          $display("%0t: x expected %h actual %h", $time, e.x, g.x);
        end
        if (g.y !== e.y) begin
          errors++;
          $display("%0t: y expected %h actual %h", $time, e.y, g.y);
        end
        if (g.z !== e.z) begin
          errors++;
          $display("%0t: z expected %h actual %h", $time, e.z, g.z);
        end
        if (g.inten !== e.inten) begin
          errors++;
          $display("%0t: intensity expected %h actual %h", $time, e.inten, g.inten);
        end
        if (g.inv !== e.inv) begin
          errors++;
          $display("%0t: invalid expected %b actual %b", $time, e.inv, g.inv);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    point_t p;
    comp_t  te;
    idle_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    frame_end = '0;
    span_recip = '0;
    shift_v = '{32'h0, 32'h0, 32'h0};
    rel_quat = 64'h8000000000000000;
    angle = '0;
    sin_recip_v = '0;
    span_ns = 1000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows under reset settings, expectations typed in
    for (int i = 0; i < NUM_ROWS; i++) begin
      p  = '{dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].inten,
             dir_rows[i].stamp, dir_rows[i].inv};
      te = '{dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez, dir_rows[i].inten,
             dir_rows[i].inv};
      send_point(p, 1'b1, te);
    end
    drain();

    // Same rows at both extreme settings, then random frames
    for (int ph = 1; ph <= 9; ph++) begin
      pick_settings(ph <= 2 ? ph : 3);
      idle_on = (ph != 9) && ($urandom_range(0, 4) != 0 || ph == 1);
      if (ph <= 2) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          p = '{dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].inten,
                dir_rows[i].stamp, dir_rows[i].inv};
          send_point(p, 1'b0, te);
        end
      end
      for (int n = 0; n < 90; n++)
        send_point(random_point(), 1'b0, te);
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
design/lpmc_pkg.sv
design/lpmc_sin_weight.sv
design/lidar_point_motion_compensation.sv
test/tb.sv
